FILE: hw/rtl/lzsr_pkg.sv
`default_nettype none
package lzsr_pkg;

  // fixed field widths
  localparam int VALUE_W = 16;
  localparam int LEN_W   = 9;

  // one input beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic             too_long;
  } result_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;  // add value to running sum, start a table scan
    logic mark_ovf;   // item beyond capacity: flag only
    logic scan;       // step the table scan
    logic commit;     // scan finished: update best, table and count
    logic report;     // load result register and clear sequence state
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;       // item count has reached capacity
    logic scan_done;  // match found or table exhausted
    logic last;       // current item closes the sequence
    logic out_free;   // result register can take a new beat
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/longest_zero_sum_run_core.sv
`default_nettype none
// Longest zero-sum run: takes one signed 16-bit value per beat and, on the
// beat marked last, returns the length of the longest contiguous run of the
// sequence that sums to zero, plus a flag set when more than MAX_ITEMS values
// arrived (the extra ones are dropped). Each distinct prefix sum is kept in a
// table RAM (one write port, one registered read port) with the index where
// it first appeared; every value scans the entries held so far (at most
// MAX_ITEMS) one entry per cycle: the block takes the value, issues the
// reads, drains the read pipeline and commits, holding off new values until
// then. An empty table needs no reads, and a match on an entry ends the scan
// there. A dropped value is only flagged and starts no scan. The last beat
// then loads the result register, waiting while an earlier result is still
// held downstream, after which the block starts a fresh sequence; new values
// are taken while a result still waits downstream.
module longest_zero_sum_run_core #(
  parameter int MAX_ITEMS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lzsr_pkg::item_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lzsr_pkg::result_t      out_data
);
  import lzsr_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  lzsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  lzsr_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (ctrl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // never overwrite a result that is still waiting
  a_report_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.report |-> dp_stat.out_free)
    else $error("report while result register busy");

  // a value past capacity must not touch the sums
  a_load_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_item |-> !dp_stat.full)
    else $error("value loaded past capacity");

  // a report always presents a beat next cycle
  a_report_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.report |=> out_valid)
    else $error("report did not produce a result beat");

  // after a report the sequence state is clear, so there is room again
  a_report_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.report |=> !dp_stat.full)
    else $error("sequence state not cleared after report");

endmodule
`default_nettype wire

FILE: hw/rtl/lzsr_ram.sv
`default_nettype none
module lzsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lzsr_ctrl.sv
`default_nettype none
module lzsr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_stall,
  input  wire lzsr_pkg::dp_stat_t   stat,
  output lzsr_pkg::ctrl_cmd_t       cmd
);
  import lzsr_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  assign take = in_valid && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (!stat.full) begin
            state_nxt = ST_SCAN;
          end else if (in_last) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = stat.last ? ST_REPORT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = take && !stat.full;
        cmd.mark_ovf  = take && stat.full;
      end
      ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.commit = stat.scan_done;
      end
      ST_REPORT: begin
        cmd.report = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lzsr_dp.sv
`default_nettype none
module lzsr_dp #(
  parameter int MAX_ITEMS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lzsr_pkg::item_t      in_data,
  input  wire lzsr_pkg::ctrl_cmd_t  cmd,
  output lzsr_pkg::dp_stat_t        stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lzsr_pkg::result_t         out_data
);
  import lzsr_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int SUM_W = VALUE_W + IDX_W + 1;
  localparam int ENT_W = SUM_W + IDX_W;

  logic [SUM_W-1:0] sum_r,   sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] used_r,  used_nxt;
  logic [CNT_W-1:0] best_r,  best_nxt;
  logic [CNT_W-1:0] k_r,     k_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             ovf_r,   ovf_nxt;
  logic             last_r,  last_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_data_r,  out_data_nxt;

  logic [ENT_W-1:0] ram_rdata;
  logic [SUM_W-1:0] rd_sum;
  logic [IDX_W-1:0] rd_first;
  logic [SUM_W-1:0] value_ext;
  logic [CNT_W-1:0] runlen;
  logic [CNT_W-1:0] zero_len;
  logic [CNT_W-1:0] best_a;
  logic             hit, more, issue, scan_done, out_free, we;

  // table entry: prefix sum and index of its first appearance
  lzsr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ITEMS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (used_r[IDX_W-1:0]),
    .wdata ({sum_r, count_r[IDX_W-1:0]}),
    .raddr (k_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // scan compare, one entry per cycle behind the read pipeline
  always_comb begin
    rd_sum    = ram_rdata[ENT_W-1:IDX_W];
    rd_first  = ram_rdata[IDX_W-1:0];
    value_ext = {{(SUM_W-VALUE_W){in_data.value[VALUE_W-1]}}, in_data.value};
    hit       = rd_vld_r && (rd_sum == sum_r);
    more      = k_r < used_r;
    issue     = cmd.scan && more && !hit;
    scan_done = hit || (!rd_vld_r && !more);
    out_free  = !out_valid_r || !out_stall;
    we        = cmd.commit && !hit;
    runlen    = count_r - CNT_W'(rd_first);
    zero_len  = count_r + CNT_W'(1);
    best_a    = ((sum_r == '0) && (zero_len > best_r)) ? zero_len : best_r;
  end

  // next values
  always_comb begin
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    best_nxt      = best_r;
    k_nxt         = k_r;
    rd_vld_nxt    = issue;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (issue) begin
      k_nxt = k_r + CNT_W'(1);
    end

    if (cmd.load_item) begin
      sum_nxt    = sum_r + value_ext;
      last_nxt   = in_data.last;
      k_nxt      = '0;
      rd_vld_nxt = 1'b0;
    end

    if (cmd.mark_ovf) begin
      ovf_nxt = 1'b1;
    end

    if (cmd.commit) begin
      best_nxt  = (hit && (runlen > best_a)) ? runlen : best_a;
      count_nxt = count_r + CNT_W'(1);
      if (!hit) begin
        used_nxt = used_r + CNT_W'(1);
      end
    end

    // result register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.report) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.best_length = LEN_W'(best_r);
      out_data_nxt.too_long    = ovf_r;
      sum_nxt                  = '0;
      count_nxt                = '0;
      used_nxt                 = '0;
      best_nxt                 = '0;
      ovf_nxt                  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      used_r      <= '0;
      best_r      <= '0;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      best_r      <= best_nxt;
      k_r         <= k_nxt;
      rd_vld_r    <= rd_vld_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    stat.full      = count_r >= CNT_W'(MAX_ITEMS);
    stat.scan_done = scan_done;
    stat.last      = last_r;
    stat.out_free  = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: verif/lzsr_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the zero-sum run core, tracks the prefix-sum table
// of the open sequence and checks every report beat against the prediction.
module lzsr_checker
  import lzsr_pkg::*;
#(
  parameter int MAX_ITEMS = 256
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_stall,
  input  wire item_t   in_data,
  input  wire logic    out_valid,
  input  wire logic    out_stall,
  input  wire result_t out_data,
  output int           mismatches,
  output int           reports_owed
);

  // state of the sequence being collected
  int      run_sum;
  int      run_count;
  int      run_best;
  int      run_entries;
  bit      run_dropped;
  int      first_sum [MAX_ITEMS];
  int      first_index [MAX_ITEMS];
  result_t pending_reports[$];
  int      error_total;

  task automatic clear_run();
    run_sum     = 0;
    run_count   = 0;
    run_best    = 0;
    run_entries = 0;
    run_dropped = 1'b0;
  endtask

  // fold one value into the prefix sums and the best run length
  task automatic absorb_value(input logic signed [VALUE_W-1:0] v);
    int  idx;
    int  k;
    bit  hit;
    hit = 1'b0;
    if (run_count >= MAX_ITEMS) begin
      run_dropped = 1'b1;
      return;
    end
    idx = run_count;
    run_sum += int'(v);
    if (run_sum == 0 && idx + 1 > run_best) run_best = idx + 1;
    for (k = 0; k < run_entries; k++) begin
      if (!hit && first_sum[k] == run_sum) begin
        if (idx - first_index[k] > run_best) run_best = idx - first_index[k];
        hit = 1'b1;
      end
    end
    if (!hit && run_entries < MAX_ITEMS) begin
      first_sum[run_entries]   = run_sum;
      first_index[run_entries] = idx;
      run_entries++;
    end
    run_count = idx + 1;
  endtask

  always @(posedge clk) begin
    result_t want;
    int      best_bits;
    if (!rst_n) begin
      clear_run();
      pending_reports.delete();
      error_total = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result beat: best_length=%0d too_long=%0d",
                 out_data.best_length, out_data.too_long);
          error_total++;
        end else begin
          want = pending_reports.pop_front();
          if (out_data.best_length !== want.best_length) begin
            $error("best_length: expected %0d, actual %0d",
                   want.best_length, out_data.best_length);
            error_total++;
          end
          if (out_data.too_long !== want.too_long) begin
            $error("too_long: expected %0d, actual %0d",
                   want.too_long, out_data.too_long);
            error_total++;
          end
        end
      end
      // input beat; the marked one closes the sequence
      if (in_valid && !in_stall) begin
        absorb_value(in_data.value);
        if (in_data.last) begin
          best_bits        = run_best;
          want.best_length = best_bits[LEN_W-1:0];
          want.too_long    = run_dropped;
          pending_reports.push_back(want);
          clear_run();
        end
      end
    end
    mismatches   <= error_total;
    reports_owed <= pending_reports.size();
  end

endmodule

FILE: verif/tb_longest_zero_sum_run_core.sv
`timescale 1ns / 1ps
module tb_longest_zero_sum_run_core;
  import lzsr_pkg::*;

  localparam int CAPACITY    = 256;
  localparam int ITEM_TARGET = 1900;
  localparam int CALM_FROM   = 1750;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 3000000;

  typedef enum int {
    STY_SMALL,
    STY_FULL,
    STY_EDGE,
    STY_ZERO,
    STY_MIRROR,
    STY_ANY
  } value_style_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  item_t   in_data   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_data;

  int mismatches;
  int reports_owed;
  int items_sent = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  bit calm       = 1'b0;
  int cycle_count = 0;
  int stall_left  = 0;

  always #2 clk = ~clk;

  longest_zero_sum_run_core #(
    .MAX_ITEMS(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  lzsr_checker #(
    .MAX_ITEMS(CAPACITY)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .reports_owed(reports_owed)
  );

  // receiver backpressure in random bursts
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** longest_zero_sum_run_core: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value(input value_style_t sty);
    value_style_t s;
    int           t;
    s = sty;
    if (s == STY_ANY) s = value_style_t'($urandom_range(0, 2));
    case (s)
      STY_FULL: begin
        t = $urandom();
      end
      STY_EDGE: begin
        case ($urandom_range(0, 4))
          0:       t = 32'h8000;
          1:       t = 32'h7FFF;
          2:       t = 32'hFFFF;
          3:       t = 1;
          default: t = 0;
        endcase
      end
      STY_ZERO: begin
        t = 0;
      end
      default: begin
        t = int'($urandom_range(0, 6)) - 3;
      end
    endcase
    return t[VALUE_W-1:0];
  endfunction

  // one beat, with an optional idle burst ahead of it
  task automatic send_beat(input logic signed [VALUE_W-1:0] v, input logic fin);
    int gap;
    calm = (items_sent >= CALM_FROM);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {v, fin};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // a whole sequence, last beat marked
  task automatic send_run(input int len, input value_style_t sty);
    logic signed [VALUE_W-1:0] vals[$];
    logic signed [VALUE_W-1:0] v;
    int                        half;
    int                        k;
    if (sty == STY_MIRROR) begin
      // second half cancels the first, so the whole run sums to zero
      half = (len + 1) / 2;
      for (k = 0; k < half; k++) begin
        v = pick_value(STY_ANY);
        if (v == 16'sh8000) v = 16'sh7FFF;
        vals.push_back(v);
      end
      for (k = half - 1; k >= 0; k--) vals.push_back(-vals[k]);
    end else begin
      for (k = 0; k < len; k++) vals.push_back(pick_value(sty));
    end
    for (k = 0; k < vals.size(); k++) send_beat(vals[k], k == vals.size() - 1);
  endtask

  // hold the sender until every report has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    int           len;
    value_style_t sty;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lone zero, lone extremes
    send_beat(16'sh0000, 1'b1);
    send_beat(16'sh7FFF, 1'b1);
    send_beat(16'sh8000, 1'b1);
    // prefix reaches zero only at the end
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(16'sh0001, 1'b0);
    send_beat(16'sh0001, 1'b1);
    // repeated prefix sum inside the run
    send_beat(16'sd3, 1'b0);
    send_beat(16'sd1, 1'b0);
    send_beat(-16'sd1, 1'b1);
    // alternating cancel
    send_beat(16'sd7, 1'b0);
    send_beat(-16'sd7, 1'b0);
    send_beat(16'sd7, 1'b0);
    send_beat(-16'sd7, 1'b1);
    // no zero run at all, then zeros after a nonzero start
    send_beat(16'sd1, 1'b0);
    send_beat(16'sd2, 1'b1);
    send_beat(16'sd5, 1'b0);
    send_beat(16'sd0, 1'b0);
    send_beat(16'sd0, 1'b1);
    drain();

    // capacity corners: full table, widest length, overflow
    gap_pct   = 5;
    stall_pct = 20;
    send_run(CAPACITY, STY_ZERO);
    send_run(CAPACITY, STY_FULL);
    send_run(CAPACITY, STY_EDGE);
    send_run(CAPACITY + $urandom_range(1, 40), STY_SMALL);
    send_run(CAPACITY + 1, STY_ANY);
    drain();

    // mostly short sequences with varied content and pacing
    while (items_sent < ITEM_TARGET) begin
      len       = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                              : $urandom_range(1, 24);
      sty       = value_style_t'($urandom_range(0, 5));
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      send_run(len, sty);
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && reports_owed == 0) begin
      $display("** longest_zero_sum_run_core: PASSED **");
    end else begin
      $display("** longest_zero_sum_run_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lzsr_pkg.sv
hw/rtl/lzsr_ram.sv
hw/rtl/lzsr_ctrl.sv
hw/rtl/lzsr_dp.sv
hw/rtl/longest_zero_sum_run_core.sv
verif/lzsr_checker.sv
verif/tb_longest_zero_sum_run_core.sv
